// ===== rtl/pcx_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants of the pcx run-length decoder
// no dependencies; every other file of the block imports this package
package pcx_pkg;

	// default image bounds
	localparam int unsigned DEF_MAX_WIDTH  = 640;
	localparam int unsigned DEF_MAX_HEIGHT = 480;

	// field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned INDEX_W = 19;
	localparam int unsigned COL_W   = 10;
	localparam int unsigned ROW_W   = 9;
	localparam int unsigned HCNT_W  = 7;
	localparam int unsigned RUN_W   = 6;
	localparam int unsigned PHASE_W = 2;

	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [COL_W-1:0]   col_t;
	typedef logic [ROW_W-1:0]   row_t;
	typedef logic [HCNT_W-1:0]  hcnt_t;
	typedef logic [RUN_W-1:0]   run_t;
	typedef logic [PHASE_W-1:0] phase_t;

	// result kinds
	localparam kind_t KIND_PIXEL  = 2'd0;
	localparam kind_t KIND_REJECT = 2'd1;
	localparam kind_t KIND_TRUNC  = 2'd2;

	// parse phases
	localparam phase_t PH_HEADER = 2'd0;
	localparam phase_t PH_DATA   = 2'd1;
	localparam phase_t PH_DONE   = 2'd2;

	// header byte positions
	localparam hcnt_t HDR_MANUF    = 7'd0;
	localparam hcnt_t HDR_VERSION  = 7'd1;
	localparam hcnt_t HDR_ENCODING = 7'd2;
	localparam hcnt_t HDR_BPP      = 7'd3;
	localparam hcnt_t HDR_XMAX_LO  = 7'd8;
	localparam hcnt_t HDR_XMAX_HI  = 7'd9;
	localparam hcnt_t HDR_YMAX_LO  = 7'd10;
	localparam hcnt_t HDR_YMAX_HI  = 7'd11;
	localparam hcnt_t HDR_LAST     = 7'd127;

	// expected header values
	localparam logic [BYTE_W-1:0] MANUF_VAL    = 8'h0A;
	localparam logic [BYTE_W-1:0] VERSION_VAL  = 8'd5;
	localparam logic [BYTE_W-1:0] ENCODING_VAL = 8'd1;
	localparam logic [BYTE_W-1:0] BPP_VAL      = 8'd8;

	// run byte marker
	localparam logic [1:0] RUN_MARK = 2'b11;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic step;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;
		logic will_work;
		logic work_pending;
		logic last_step;
	} dp_status_t;

endpackage

// ===== rtl/pcx_in_if.sv =====
`timescale 1ns / 1ps
// byte channel of the pcx decoder: valid/ready with one file byte per beat
// depends on pcx_pkg
interface pcx_in_if;
	import pcx_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              file_start;
	logic              file_end;

	modport source (output valid, data_byte, file_start, file_end, input ready);
	modport sink (input valid, data_byte, file_start, file_end, output ready);
endinterface

// ===== rtl/pcx_out_if.sv =====
`timescale 1ns / 1ps
// result channel of the pcx decoder: valid/ready with one pixel or status per beat
// depends on pcx_pkg
interface pcx_out_if;
	import pcx_pkg::*;

	logic              valid;
	logic              ready;
	kind_t             kind;
	index_t            pixel_index;
	logic [BYTE_W-1:0] pixel_value;
	col_t              image_width;
	row_t              image_height;
	logic              final_res;

	modport source (output valid, kind, pixel_index, pixel_value, image_width,
		image_height, final_res, input ready);
	modport sink (input valid, kind, pixel_index, pixel_value, image_width,
		image_height, final_res, output ready);
endinterface

// ===== rtl/pcx_dp.sv =====
`timescale 1ns / 1ps
// pcx datapath: header parse, run state, pixel position and the result register
// depends on pcx_pkg; driven by pcx_ctrl through dp_cmd_t / dp_status_t
module pcx_dp #(
	parameter int unsigned MAX_WIDTH  = pcx_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = pcx_pkg::DEF_MAX_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [pcx_pkg::BYTE_W-1:0] data_byte,
	input  logic                      file_start,
	input  logic                      file_end,
	input  pcx_pkg::dp_cmd_t          cmd,
	output pcx_pkg::dp_status_t       status,
	input  logic                      out_ready,
	output logic                      out_valid,
	output pcx_pkg::kind_t            kind,
	output pcx_pkg::index_t           pixel_index,
	output logic [pcx_pkg::BYTE_W-1:0] pixel_value,
	output pcx_pkg::col_t             image_width,
	output pcx_pkg::row_t             image_height,
	output logic                      final_res
);
	import pcx_pkg::*;

	// parse state
	hcnt_t  header_count_q, hc_n;
	phase_t phase_q, ph_n;
	col_t   last_column_q, lc_n;
	row_t   last_row_q, lr_n;
	logic   header_bad_q, bad_n;
	logic   run_armed_q, armed_n;
	run_t   run_count_q, cnt_n;
	col_t   cur_column_q, col_n;
	row_t   cur_row_q, row_n;
	index_t linear_index_q, lin_n;
	run_t   run_left_q, left_n;
	logic [BYTE_W-1:0] run_val_q, val_n;
	logic   fe_pend_q, fe_n;

	// result register
	logic   out_valid_q;
	kind_t  kind_q;
	index_t index_q;
	logic [BYTE_W-1:0] value_q;
	col_t   width_q;
	row_t   height_q;
	logic   final_q;

	// values after a file start clears parsing
	hcnt_t  eff_hc;
	phase_t eff_ph;
	col_t   eff_lc;
	row_t   eff_lr;
	logic   eff_bad;
	logic   eff_armed;

	// result to load
	logic   ld;
	kind_t  o_kind;
	index_t o_index;
	logic [BYTE_W-1:0] o_value;
	col_t   o_width;
	row_t   o_height;
	logic   o_final;

	logic   mismatch;
	logic [15:0] full_x, full_y;
	logic   last_col, img_done;

	assign full_x   = {data_byte, eff_lc[7:0]};
	assign full_y   = {data_byte, eff_lr[7:0]};
	assign last_col = (cur_column_q == last_column_q);
	assign img_done = last_col && (cur_row_q == last_row_q);

	// file start restarts parsing
	always_comb begin
		if (file_start) begin
			eff_hc    = '0;
			eff_ph    = PH_HEADER;
			eff_lc    = '0;
			eff_lr    = '0;
			eff_bad   = 1'b0;
			eff_armed = 1'b0;
		end else begin
			eff_hc    = header_count_q;
			eff_ph    = phase_q;
			eff_lc    = last_column_q;
			eff_lr    = last_row_q;
			eff_bad   = header_bad_q;
			eff_armed = run_armed_q;
		end
	end

	// header field check
	always_comb begin
		unique case (eff_hc)
			HDR_MANUF:    mismatch = (data_byte != MANUF_VAL);
			HDR_VERSION:  mismatch = (data_byte != VERSION_VAL);
			HDR_ENCODING: mismatch = (data_byte != ENCODING_VAL);
			HDR_BPP:      mismatch = (data_byte != BPP_VAL);
			HDR_XMAX_HI:  mismatch = (full_x >= 16'(MAX_WIDTH));
			HDR_YMAX_HI:  mismatch = (full_y >= 16'(MAX_HEIGHT));
			default:      mismatch = 1'b0;
		endcase
	end

	// next state and result
	always_comb begin
		hc_n    = header_count_q;
		ph_n    = phase_q;
		lc_n    = last_column_q;
		lr_n    = last_row_q;
		bad_n   = header_bad_q;
		armed_n = run_armed_q;
		cnt_n   = run_count_q;
		col_n   = cur_column_q;
		row_n   = cur_row_q;
		lin_n   = linear_index_q;
		left_n  = run_left_q;
		val_n   = run_val_q;
		fe_n    = fe_pend_q;
		ld       = 1'b0;
		o_kind   = KIND_PIXEL;
		o_index  = '0;
		o_value  = '0;
		o_width  = '0;
		o_height = '0;
		o_final  = 1'b0;
		if (cmd.accept) begin
			hc_n    = eff_hc;
			ph_n    = eff_ph;
			lc_n    = eff_lc;
			lr_n    = eff_lr;
			bad_n   = eff_bad | ((eff_ph == PH_HEADER) & mismatch);
			armed_n = eff_armed;
			left_n  = '0;
			fe_n    = 1'b0;
			unique case (eff_ph)
				PH_HEADER: begin
					if (eff_hc == HDR_XMAX_LO) lc_n = {2'b00, data_byte};
					if (eff_hc == HDR_XMAX_HI) lc_n = full_x[COL_W-1:0];
					if (eff_hc == HDR_YMAX_LO) lr_n = {1'b0, data_byte};
					if (eff_hc == HDR_YMAX_HI) lr_n = full_y[ROW_W-1:0];
					if (eff_hc == HDR_LAST) begin
						if (bad_n) begin
							ld      = 1'b1;
							o_kind  = KIND_REJECT;
							o_final = 1'b1;
							ph_n    = PH_DONE;
						end else begin
							ph_n    = PH_DATA;
							col_n   = '0;
							row_n   = '0;
							lin_n   = '0;
							armed_n = 1'b0;
							cnt_n   = '0;
							if (file_end) begin
								ld       = 1'b1;
								o_kind   = KIND_TRUNC;
								o_width  = eff_lc + 1'b1;
								o_height = eff_lr + 1'b1;
								o_final  = 1'b1;
								ph_n     = PH_DONE;
							end
						end
					end else begin
						hc_n = eff_hc + 1'b1;
						if (file_end) begin
							ld      = 1'b1;
							o_kind  = KIND_REJECT;
							o_final = 1'b1;
							ph_n    = PH_DONE;
						end
					end
				end
				PH_DATA: begin
					fe_n = file_end;
					if (eff_armed) begin
						armed_n = 1'b0;
						left_n  = run_count_q;
						val_n   = data_byte;
					end else if (data_byte[7:6] == RUN_MARK) begin
						armed_n = 1'b1;
						cnt_n   = data_byte[RUN_W-1:0];
					end else begin
						left_n = run_t'(1);
						val_n  = data_byte;
					end
				end
				default: ;
			endcase
		end else if (cmd.step) begin
			ld       = 1'b1;
			o_index  = linear_index_q;
			o_width  = last_column_q + 1'b1;
			o_height = last_row_q + 1'b1;
			if (run_left_q != '0) begin
				// one pixel of the run
				o_kind  = KIND_PIXEL;
				o_value = run_val_q;
				o_final = img_done;
				lin_n   = linear_index_q + 1'b1;
				if (img_done) begin
					ph_n = PH_DONE;
				end else if (last_col) begin
					col_n  = '0;
					row_n  = cur_row_q + 1'b1;
					left_n = '0;
				end else begin
					col_n  = cur_column_q + 1'b1;
					left_n = run_left_q - 1'b1;
				end
			end else begin
				// file ended early
				o_kind  = KIND_TRUNC;
				o_final = 1'b1;
				ph_n    = PH_DONE;
				fe_n    = 1'b0;
			end
		end
	end

	// status to the controller
	always_comb begin
		status.slot_free    = !out_valid_q || out_ready;
		status.will_work    = !file_start && (phase_q == PH_DATA) &&
			(file_end || (run_armed_q ? (run_count_q != '0) : (data_byte[7:6] != RUN_MARK)));
		status.work_pending = (phase_q == PH_DATA) && ((run_left_q != '0) || fe_pend_q);
		status.last_step    = (run_left_q == '0) || img_done ||
			(((run_left_q == run_t'(1)) || last_col) && !fe_pend_q);
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= '0;
			phase_q        <= PH_HEADER;
			last_column_q  <= '0;
			last_row_q     <= '0;
			header_bad_q   <= 1'b0;
			run_armed_q    <= 1'b0;
			run_count_q    <= '0;
			cur_column_q   <= '0;
			cur_row_q      <= '0;
			linear_index_q <= '0;
			run_left_q     <= '0;
			fe_pend_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			header_count_q <= hc_n;
			phase_q        <= ph_n;
			last_column_q  <= lc_n;
			last_row_q     <= lr_n;
			header_bad_q   <= bad_n;
			run_armed_q    <= armed_n;
			run_count_q    <= cnt_n;
			cur_column_q   <= col_n;
			cur_row_q      <= row_n;
			linear_index_q <= lin_n;
			run_left_q     <= left_n;
			fe_pend_q      <= fe_n;
			if (ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// result payload and run value
	always_ff @(posedge clk) begin
		run_val_q <= val_n;
		if (ld) begin
			kind_q   <= o_kind;
			index_q  <= o_index;
			value_q  <= o_value;
			width_q  <= o_width;
			height_q <= o_height;
			final_q  <= o_final;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign pixel_index  = index_q;
	assign pixel_value  = value_q;
	assign image_width  = width_q;
	assign image_height = height_q;
	assign final_res    = final_q;
endmodule

// ===== rtl/pcx_ctrl.sv =====
`timescale 1ns / 1ps
// pcx controller: takes bytes while idle, then steps the datapath once per result
// depends on pcx_pkg
module pcx_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  pcx_pkg::dp_status_t status,
	output logic                ready,
	output pcx_pkg::dp_cmd_t    cmd
);
	import pcx_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q, state_n;

	// handshake and commands
	assign ready      = (state_q == ST_IDLE) && status.slot_free;
	assign cmd.accept = in_valid && ready;
	assign cmd.step   = (state_q == ST_EMIT) && status.slot_free && status.work_pending;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd.accept && status.will_work) state_n = ST_EMIT;
			ST_EMIT: begin
				if (!status.work_pending || (cmd.step && status.last_step)) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_n;
	end
endmodule

// ===== rtl/pcx_rle_decoder_unit.sv =====
`timescale 1ns / 1ps
// pcx 8bpp run-length decoder, one file byte per beat in, one result per beat out
// output: each result is registered and is at the output in the cycle after the beat or step that makes it
// throughput: a data byte's run expands one pixel per cycle while the result channel is ready,
// through the single result register; no new file byte is taken until the run is through
// reset: asynchronous, clears the parse state except the run value; parsing restarts at header byte 0
// depends on pcx_pkg, pcx_in_if, pcx_out_if, pcx_ctrl, pcx_dp
module pcx_rle_decoder_unit #(
	parameter int unsigned MAX_WIDTH  = pcx_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = pcx_pkg::DEF_MAX_HEIGHT
) (
	input logic      clk,
	input logic      arst_n,
	pcx_in_if.sink   file_bytes,
	pcx_out_if.source results
);
	import pcx_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// controller
	pcx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (file_bytes.valid),
		.status   (status),
		.ready    (file_bytes.ready),
		.cmd      (cmd)
	);

	// datapath
	pcx_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (file_bytes.data_byte),
		.file_start   (file_bytes.file_start),
		.file_end     (file_bytes.file_end),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (results.ready),
		.out_valid    (results.valid),
		.kind         (results.kind),
		.pixel_index  (results.pixel_index),
		.pixel_value  (results.pixel_value),
		.image_width  (results.image_width),
		.image_height (results.image_height),
		.final_res    (results.final_res)
	);
endmodule
